// ===== rtl/content_length_message_deframer_assert.svh =====
// assertion macros for the content-length deframer
// no dependencies; included by files that carry concurrent checks
`ifndef CONTENT_LENGTH_MESSAGE_DEFRAMER_ASSERT_SVH
`define CONTENT_LENGTH_MESSAGE_DEFRAMER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// checked property, ignored while reset is asserted
`define CLMD_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) else $error(msg);
// checked property, also during reset
`define CLMD_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) (prop)) else $error(msg);
`else
`define CLMD_ASSERT(lbl, clk_s, rstn_s, prop, msg)
`define CLMD_ASSERT_ALWAYS(lbl, clk_s, prop, msg)
`endif

`endif

// ===== rtl/clmd_pkg.sv =====
// types, codes and constants of the content-length deframer
// no dependencies; used by content_length_message_deframer
`default_nettype none

package clmd_pkg;

    localparam int LENGTH_BITS_DEF = 32;
    localparam int OUT_DATA_W      = 48;   // 8 + 2 + 32 bits, padded to whole bytes
    localparam int QUEUE_DEPTH     = 4;
    localparam int QUEUE_AW        = 2;

    localparam logic [7:0] CHAR_CR  = 8'd13;
    localparam logic [7:0] CHAR_LF  = 8'd10;
    localparam logic [7:0] CHAR_SP  = 8'd32;
    localparam logic [7:0] CHAR_TAB = 8'd9;
    localparam logic [7:0] CHAR_D0  = 8'd48;
    localparam logic [7:0] CHAR_D9  = 8'd57;

    localparam logic [3:0] PREFIX_DONE = 4'd15;

    localparam logic KIND_BODY   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_BLANK = 2'd1;
    localparam logic [1:0] ST_BAD_HDR  = 2'd2;
    localparam logic [1:0] ST_SHORT    = 2'd3;

    typedef enum logic [2:0] {
        PH_HEADER = 3'b001,
        PH_SEARCH = 3'b010,
        PH_BODY   = 3'b100
    } phase_t;

    typedef enum logic [2:0] {
        FLD_LEAD   = 3'b001,
        FLD_DIGITS = 3'b010,
        FLD_TRAIL  = 3'b100
    } field_stage_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  body_byte;
        logic [1:0]  status;
        logic [31:0] length_value;
    } result_t;

    // expected characters of "Content-Length:"
    function automatic logic [7:0] prefix_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h43;  // C
            4'd1:    c = 8'h6f;  // o
            4'd2:    c = 8'h6e;  // n
            4'd3:    c = 8'h74;  // t
            4'd4:    c = 8'h65;  // e
            4'd5:    c = 8'h6e;  // n
            4'd6:    c = 8'h74;  // t
            4'd7:    c = 8'h2d;  // -
            4'd8:    c = 8'h4c;  // L
            4'd9:    c = 8'h65;  // e
            4'd10:   c = 8'h6e;  // n
            4'd11:   c = 8'h67;  // g
            4'd12:   c = 8'h74;  // t
            4'd13:   c = 8'h68;  // h
            4'd14:   c = 8'h3a;  // :
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/content_length_message_deframer.sv =====
// content-length message deframer: one byte per cycle while s_axis_tready is high,
// per-byte parser state, results queued in a four-entry output queue
// depends on clmd_pkg and content_length_message_deframer_assert.svh
// results enter the output queue as their bytes are accepted; m_axis presents the head
// throughput: one byte per cycle while s_axis_tready is high; a final byte that is
// also a body byte gives two results, drained one per cycle while m_axis_tready is high
// s_axis_tready is high while the output queue has room for two results (count <= 2)
// reset: asynchronous, active low; clears parser state and empties the queue
`default_nettype none
`include "content_length_message_deframer_assert.svh"

module content_length_message_deframer
    import clmd_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
)(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [7:0]            s_axis_tdata,   // [7:0] data_byte
    input  wire logic                  s_axis_tlast,   // end_of_buffer
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,   // [7:0] body_byte, [9:8] status,
                                                       // [41:10] length_value, rest zero
    output logic                       m_axis_tuser    // kind
);

    localparam int PROD_W = LENGTH_BITS + 4;

    // parser state
    phase_t                 phase_reg,   phase_next;
    logic [3:0]             pidx_reg,    pidx_next;
    field_stage_t           stage_reg,   stage_next;
    logic [LENGTH_BITS-1:0] acc_reg,     acc_next;
    logic                   bad_reg,     bad_next;
    logic                   pend_cr_reg, pend_cr_next;
    logic [1:0]             term_reg,    term_next;
    logic [LENGTH_BITS-1:0] rem_reg,     rem_next;

    // output queue
    result_t                queue_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]      count_reg,  count_next;

    logic                   in_fire;
    logic                   out_fire;
    logic [7:0]             b;
    logic                   body_emit;
    logic [1:0]             final_status;
    logic [PROD_W-1:0]      prod;
    logic [63:0]            acc_wide;
    logic [7:0]             term_char;
    result_t                res_body;
    result_t                res_stat;
    result_t                res_first;
    logic [1:0]             push_n;

    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_fire      = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (count_reg <= (QUEUE_AW+1)'(QUEUE_DEPTH - 2));
    assign b             = s_axis_tdata;

    // acc * 10 + digit, checked for overflow in the top bits
    assign prod = (PROD_W'(acc_reg) << 3) + (PROD_W'(acc_reg) << 1) + PROD_W'(b[3:0]);

    always_comb
    begin
        phase_next   = phase_reg;
        pidx_next    = pidx_reg;
        stage_next   = stage_reg;
        acc_next     = acc_reg;
        bad_next     = bad_reg;
        pend_cr_next = pend_cr_reg;
        term_next    = term_reg;
        rem_next     = rem_reg;
        body_emit    = 1'b0;
        final_status = ST_OK;
        term_char    = term_reg[0] ? CHAR_LF : CHAR_CR;

        if (phase_reg == PH_BODY)
        begin
            if (rem_reg != '0)
            begin
                rem_next  = rem_reg - 1'b1;
                body_emit = !bad_reg;
            end
        end
        else
        begin
            if (phase_reg == PH_HEADER)
            begin
                if (pend_cr_reg && b == CHAR_LF)
                begin
                    pend_cr_next = 1'b0;
                    if (pidx_reg != PREFIX_DONE || stage_reg == FLD_LEAD)
                        bad_next = 1'b1;
                    phase_next = PH_SEARCH;
                end
                else
                begin
                    if (pend_cr_reg)
                        bad_next = 1'b1;
                    pend_cr_next = 1'b0;
                    if (b == CHAR_CR)
                        pend_cr_next = 1'b1;
                    else if (pidx_reg != PREFIX_DONE)
                    begin
                        if (b == prefix_char(pidx_reg))
                            pidx_next = pidx_reg + 1'b1;
                        else
                            bad_next = 1'b1;
                    end
                    else if (b inside {[CHAR_D0:CHAR_D9]})
                    begin
                        if (stage_reg == FLD_TRAIL)
                            bad_next = 1'b1;
                        else
                        begin
                            stage_next = FLD_DIGITS;
                            if (prod[PROD_W-1:LENGTH_BITS] != '0)
                                bad_next = 1'b1;
                            else
                                acc_next = prod[LENGTH_BITS-1:0];
                        end
                    end
                    else if (b inside {CHAR_SP, CHAR_TAB})
                    begin
                        if (stage_reg == FLD_DIGITS)
                            stage_next = FLD_TRAIL;
                    end
                    else
                        bad_next = 1'b1;
                end
            end

            // blank line search runs alongside the header line parse
            if (b == term_char)
            begin
                if (term_reg == 2'd3)
                begin
                    term_next  = 2'd0;
                    phase_next = PH_BODY;
                    rem_next   = bad_next ? '0 : acc_next;
                end
                else
                    term_next = term_reg + 1'b1;
            end
            else
                term_next = (b == CHAR_CR) ? 2'd1 : 2'd0;
        end

        if (phase_next != PH_BODY)
            final_status = ST_NO_BLANK;
        else if (bad_next)
            final_status = ST_BAD_HDR;
        else if (rem_next != '0)
            final_status = ST_SHORT;
        else
            final_status = ST_OK;

        acc_wide = 64'(acc_next);

        res_body.kind         = KIND_BODY;
        res_body.body_byte    = b;
        res_body.status       = ST_OK;
        res_body.length_value = '0;

        res_stat.kind         = KIND_STATUS;
        res_stat.body_byte    = '0;
        res_stat.status       = final_status;
        res_stat.length_value = (final_status == ST_OK) ? acc_wide[31:0] : '0;

        res_first = body_emit ? res_body : res_stat;
        push_n    = in_fire ? (2'(body_emit) + 2'(s_axis_tlast)) : 2'd0;

        // the message ends: back to the start state for the next one
        if (s_axis_tlast)
        begin
            phase_next   = PH_HEADER;
            pidx_next    = '0;
            stage_next   = FLD_LEAD;
            acc_next     = '0;
            bad_next     = 1'b0;
            pend_cr_next = 1'b0;
            term_next    = '0;
            rem_next     = '0;
        end

        wr_ptr_next = wr_ptr_reg + QUEUE_AW'(push_n);
        rd_ptr_next = rd_ptr_reg + QUEUE_AW'(out_fire);
        count_next  = count_reg + (QUEUE_AW+1)'(push_n) - (QUEUE_AW+1)'(out_fire);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HEADER;
            pidx_reg    <= '0;
            stage_reg   <= FLD_LEAD;
            acc_reg     <= '0;
            bad_reg     <= 1'b0;
            pend_cr_reg <= 1'b0;
            term_reg    <= '0;
            rem_reg     <= '0;
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            count_reg   <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                phase_reg   <= phase_next;
                pidx_reg    <= pidx_next;
                stage_reg   <= stage_next;
                acc_reg     <= acc_next;
                bad_reg     <= bad_next;
                pend_cr_reg <= pend_cr_next;
                term_reg    <= term_next;
                rem_reg     <= rem_next;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
            queue_reg[wr_ptr_reg] <= res_first;
        if (push_n == 2'd2)
            queue_reg[wr_ptr_reg + 1'b1] <= res_stat;
    end

    assign m_axis_tvalid = (count_reg != '0);
    assign m_axis_tuser  = queue_reg[rd_ptr_reg].kind;
    assign m_axis_tdata  = {{(OUT_DATA_W - 42){1'b0}},
                            queue_reg[rd_ptr_reg].length_value,
                            queue_reg[rd_ptr_reg].status,
                            queue_reg[rd_ptr_reg].body_byte};

    `CLMD_ASSERT(a_end_restarts, clk, rst_n,
        (in_fire && s_axis_tlast) |=> (phase_reg == PH_HEADER && term_reg == 2'd0),
        "parser did not return to start after end of buffer")
    `CLMD_ASSERT(a_bad_no_body, clk, rst_n,
        (phase_reg == PH_BODY && bad_reg) |-> (rem_reg == '0),
        "body count loaded after a bad header")
    `CLMD_ASSERT(a_body_fields, clk, rst_n,
        (m_axis_tvalid && m_axis_tuser == KIND_BODY) |->
            (m_axis_tdata[41:8] == '0),
        "body result carries status or length bits")
    `CLMD_ASSERT(a_queue_bound, clk, rst_n,
        count_reg <= (QUEUE_AW+1)'(QUEUE_DEPTH),
        "output queue overfilled")

endmodule

`default_nettype wire
